[sv/etr_pkg.sv]
// ============================================================================
// etr_pkg
// Shared types, widths and tables for the Euler angle to rotation matrix block.
// ============================================================================
package etr_pkg;

  // Angle and fixed point formats.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ANGLE_W    = 16;
  localparam int OUT_W      = 16;

  // CORDIC datapath: Q3.30 coordinates, 32-bit-per-turn residual angle.
  localparam int ITERS    = 24;
  localparam int INT_FRAC = 30;
  localparam int XY_W     = 34;
  localparam int Z_W      = 33;
  localparam int RSH      = INT_FRAC - FRAC_BITS;

  // Sine and cosine after rounding: Q1.FRAC_BITS with room for plus one.
  localparam int SC_W = FRAC_BITS + 2;
  // Full-width matrix sums before the last rounding.
  localparam int PW   = 2 * SC_W + 2;

  // Pipeline depth from input register to output register.
  localparam int CORDIC_LAT = ITERS + 2;
  localparam int LAT        = CORDIC_LAT + 3;

  localparam logic signed [XY_W-1:0] GAIN_INV = XY_W'(652032874);

  localparam logic signed [Z_W-1:0] ATAN_TAB [ITERS] = '{
    Z_W'(536870912), Z_W'(316933406), Z_W'(167458907), Z_W'(85004756),
    Z_W'(42667331),  Z_W'(21354465),  Z_W'(10679838),  Z_W'(5340245),
    Z_W'(2670163),   Z_W'(1335087),   Z_W'(667544),    Z_W'(333772),
    Z_W'(166886),    Z_W'(83443),     Z_W'(41722),     Z_W'(20861),
    Z_W'(10430),     Z_W'(5215),      Z_W'(2608),      Z_W'(1304),
    Z_W'(652),       Z_W'(326),       Z_W'(163),       Z_W'(81)
  };

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_x;
    logic [ANGLE_W-1:0] angle_y;
    logic [ANGLE_W-1:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m22;
  } matrix_t;

  // Round a product of two Q1.F values back to Q1.F, half rounding up.
  function automatic logic signed [SC_W-1:0] mul_rnd(input logic signed [SC_W-1:0] a,
                                                     input logic signed [SC_W-1:0] b);
    logic signed [2*SC_W-1:0] p;
    p = a * b + (2*SC_W)'(1 <<< (FRAC_BITS - 1));
    return SC_W'(p >>> FRAC_BITS);
  endfunction

  // Saturate a full-width value to plus or minus one and fit the output field.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] one;
    logic signed [PW-1:0] r;
    one = PW'(1) <<< FRAC_BITS;
    if (v > one) r = one;
    else if (v < -one) r = -one;
    else r = v;
    return OUT_W'(r);
  endfunction

endpackage

[sv/euler_to_rotation_matrix.sv]
// ============================================================================
// euler_to_rotation_matrix
// Converts an x, y, z binary angle triple to a Q1.14 rotation matrix.
// ============================================================================
// Usage:
// The input channel (in_valid_i, in_ready_o, in_data_i) takes one word of
// three 16-bit binary angles, a full turn being 65536. The output channel
// (out_valid_o, out_ready_i, out_data_o) returns one word of nine signed
// Q1.14 matrix entries, each saturated to plus or minus 16384.
// The pipeline has 29 register stages: one input register, 24 CORDIC
// iteration stages, one quadrant and rounding stage, and three product and
// saturation stages. Throughput is one word per cycle while the receiver
// keeps up; the three angles run in parallel CORDIC lanes.
// Reset clears all valid bits; the datapath registers are not reset.
// When the receiver stalls with a word waiting at the output, the whole
// pipeline holds and in_ready_o drops; no word is lost or repeated.
// ============================================================================
module euler_to_rotation_matrix
  import etr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  angles_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output matrix_t out_data_o
);

  logic [LAT-1:0]         valid_q;
  logic                   en;
  logic signed [SC_W-1:0] ci, si, cj, sj, ch, sh;

  // The pipeline advances unless a finished word is waiting.
  assign en          = !valid_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_valid_i};
    end
  end

  // Sine and cosine lanes, one per axis.
  etr_cordic u_cordic_x (.clk_i, .en_i(en), .angle_i(in_data_i.angle_x),
                         .cos_o(ci), .sin_o(si));
  etr_cordic u_cordic_y (.clk_i, .en_i(en), .angle_i(in_data_i.angle_y),
                         .cos_o(cj), .sin_o(sj));
  etr_cordic u_cordic_z (.clk_i, .en_i(en), .angle_i(in_data_i.angle_z),
                         .cos_o(ch), .sin_o(sh));

  etr_matrix u_matrix (
    .clk_i,
    .en_i  (en),
    .ci_i  (ci),
    .si_i  (si),
    .cj_i  (cj),
    .sj_i  (sj),
    .ch_i  (ch),
    .sh_i  (sh),
    .mat_o (out_data_o)
  );

  // A stall freezes every valid bit.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q)) else $error("valid bits moved during a stall");

  // An accepted word enters the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0]) else $error("accepted word dropped");

  // Delivered entries m00 and m11 stay within plus or minus one.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.m00 <= 16384 && out_data_o.m00 >= -16384 &&
                     out_data_o.m11 <= 16384 && out_data_o.m11 >= -16384))
    else $error("matrix entry out of range");

endmodule

[sv/etr_cordic.sv]
// ============================================================================
// etr_cordic
// Pipelined rotation-mode CORDIC, one iteration per stage, giving cosine and
// sine of a binary angle in Q1.FRAC_BITS.
// ============================================================================
module etr_cordic
  import etr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [ANGLE_W-1:0]     angle_i,
  output logic signed [SC_W-1:0] cos_o,
  output logic signed [SC_W-1:0] sin_o
);

  logic signed [XY_W-1:0] x_q [ITERS+1];
  logic signed [XY_W-1:0] y_q [ITERS+1];
  logic signed [Z_W-1:0]  z_q [ITERS+1];
  logic [1:0]             quad_q [ITERS+1];
  logic [31:0]            turn32;
  logic signed [XY_W-1:0] c_sel, s_sel, c_rnd, s_rnd;
  logic signed [SC_W-1:0] cos_q, sin_q;

  // Scale the angle to 32 bits per turn: quadrant on top, residual below.
  assign turn32 = 32'(angle_i[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN_INV;
      y_q[0]    <= '0;
      z_q[0]    <= Z_W'(turn32[29:0]);
      quad_q[0] <= turn32[31:30];
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][Z_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_TAB[i];
        end
      end
    end
  end

  // Quadrant fold, then round and clamp to plus or minus one.
  always_comb begin
    case (quad_q[ITERS])
      2'd0:    begin c_sel = x_q[ITERS];  s_sel = y_q[ITERS];  end
      2'd1:    begin c_sel = -y_q[ITERS]; s_sel = x_q[ITERS];  end
      2'd2:    begin c_sel = -x_q[ITERS]; s_sel = -y_q[ITERS]; end
      default: begin c_sel = y_q[ITERS];  s_sel = -x_q[ITERS]; end
    endcase
    c_rnd = (c_sel + (XY_W'(1) <<< (RSH - 1))) >>> RSH;
    s_rnd = (s_sel + (XY_W'(1) <<< (RSH - 1))) >>> RSH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= SC_W'(sat_out(PW'(c_rnd)) >>> 0);
      sin_q <= SC_W'(sat_out(PW'(s_rnd)) >>> 0);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[sv/etr_matrix.sv]
// ============================================================================
// etr_matrix
// Three-stage product network that builds the nine rotation matrix entries
// from the three sine and cosine pairs.
// ============================================================================
module etr_matrix
  import etr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [SC_W-1:0] ci_i,
  input  logic signed [SC_W-1:0] si_i,
  input  logic signed [SC_W-1:0] cj_i,
  input  logic signed [SC_W-1:0] sj_i,
  input  logic signed [SC_W-1:0] ch_i,
  input  logic signed [SC_W-1:0] sh_i,
  output matrix_t                mat_o
);

  logic signed [SC_W-1:0] cc_q, cs_q, sc_q, ss_q, sj_q;
  logic signed [SC_W-1:0] a00_q, a01_q, a02_q, a12_q, a22_q;
  logic signed [PW-1:0]   s10_q, s20_q, s11_q, s21_q;
  logic signed [PW-1:0]   b00_q, b01_q, b02_q, b12_q, b22_q;
  logic signed [PW-1:0]   half;
  matrix_t                mat_q;

  assign half = PW'(1) <<< (FRAC_BITS - 1);

  // Stage one: pair products and the entries that need at most one product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q  <= mul_rnd(ci_i, ch_i);
      cs_q  <= mul_rnd(ci_i, sh_i);
      sc_q  <= mul_rnd(si_i, ch_i);
      ss_q  <= mul_rnd(si_i, sh_i);
      sj_q  <= sj_i;
      a00_q <= mul_rnd(cj_i, ch_i);
      a01_q <= mul_rnd(cj_i, sh_i);
      a02_q <= -sj_i;
      a12_q <= mul_rnd(cj_i, si_i);
      a22_q <= mul_rnd(cj_i, ci_i);
    end
  end

  // Stage two: full-width sums with the rounding offset added.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s10_q <= PW'(sj_q) * PW'(sc_q) - (PW'(cs_q) <<< FRAC_BITS) + half;
      s20_q <= PW'(sj_q) * PW'(cc_q) + (PW'(ss_q) <<< FRAC_BITS) + half;
      s11_q <= PW'(sj_q) * PW'(ss_q) + (PW'(cc_q) <<< FRAC_BITS) + half;
      s21_q <= PW'(sj_q) * PW'(cs_q) - (PW'(sc_q) <<< FRAC_BITS) + half;
      b00_q <= PW'(a00_q);
      b01_q <= PW'(a01_q);
      b02_q <= PW'(a02_q);
      b12_q <= PW'(a12_q);
      b22_q <= PW'(a22_q);
    end
  end

  // Stage three: final shift and saturation into the output word.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q.m00 <= sat_out(b00_q);
      mat_q.m10 <= sat_out(s10_q >>> FRAC_BITS);
      mat_q.m20 <= sat_out(s20_q >>> FRAC_BITS);
      mat_q.m01 <= sat_out(b01_q);
      mat_q.m11 <= sat_out(s11_q >>> FRAC_BITS);
      mat_q.m21 <= sat_out(s21_q >>> FRAC_BITS);
      mat_q.m02 <= sat_out(b02_q);
      mat_q.m12 <= sat_out(b12_q);
      mat_q.m22 <= sat_out(b22_q);
    end
  end

  assign mat_o = mat_q;

endmodule
